[rtl/core/exception_stacking_sequencer_assert.svh]
// Assertion macros for the exception stacking sequencer checker.
// Included by the checker module only.
`ifndef EXCEPTION_STACKING_SEQUENCER_ASSERT_SVH
`define EXCEPTION_STACKING_SEQUENCER_ASSERT_SVH

// Clocked implication with synchronous reset disable.
`define ESS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Clocked next-cycle implication with reset disable.
`define ESS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ess_pkg.sv]
// Package for the exception stacking sequencer: item types, codes, states.
// No dependencies.
`default_nettype none
package ess_pkg;
   localparam int NumExceptionsDefault = 32;

   typedef enum logic [1:0] {
      REQ_RAISE = 2'd0,
      REQ_TAKE  = 2'd1,
      REQ_RET   = 2'd2,
      REQ_DATA  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_REG   = 2'd2,
      KIND_ERR   = 2'd3
   } rsp_kind_type;

   localparam logic [3:0] TGT_LR   = 4'd5;
   localparam logic [3:0] TGT_PC   = 4'd6;
   localparam logic [3:0] TGT_SP   = 4'd7;
   localparam logic [3:0] TGT_APSR = 4'd8;
   localparam logic [3:0] TGT_IPSR = 4'd9;
   localparam logic [3:0] TGT_MODE = 4'd10;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] pending_mask;
      logic [31:0] data_word;
      logic [31:0] reg_r0;
      logic [31:0] reg_r1;
      logic [31:0] reg_r2;
      logic [31:0] reg_r3;
      logic [31:0] reg_r12;
      logic [31:0] reg_lr;
      logic [31:0] reg_pc;
      logic [31:0] reg_apsr;
      logic [31:0] reg_sp;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  target;
      logic [31:0] address;
      logic [31:0] value;
      logic        last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_ENTRY_REGS,
      ST_VEC_WAIT,
      ST_RET_REGS,
      ST_FRAME_WAIT,
      ST_POP_TAIL
   } state_type;

   // Result selectors the controller hands to the datapath.
   typedef enum logic [3:0] {
      SEL_NONE,
      SEL_PUSH,
      SEL_LR,
      SEL_SP,
      SEL_MODE,
      SEL_IPSR,
      SEL_VEC,
      SEL_PC,
      SEL_FRAME_REG,
      SEL_FRAME_READ,
      SEL_APSR,
      SEL_ERR
   } sel_type;

   typedef struct packed {
      logic    latch_regs;   // take: capture caller registers
      logic    raise;        // merge pending bits
      logic    enter;        // commit entry state at the exception found
      logic    do_return;    // commit return mode and sp
      logic    store_pc;     // vector word into pc
      logic    store_frame;  // frame word into its register
      logic    pop_sp;       // sp += 32
      logic    clr_count;
      logic    inc_count;
      sel_type sel;
      logic    emit;
      logic    last;
   } ctrl_type;

   typedef struct packed {
      logic       found;      // pending bit found by the search
      logic       ret_valid;  // EXC_RETURN code is legal
      logic       ret_phase;  // return accepted, ipsr result still due
      logic [2:0] count;      // word counter
   } status_type;
endpackage
`default_nettype wire

[rtl/core/ess_ctrl.sv]
// Controller state machine of the exception stacking sequencer.
// Uses ess_pkg; drives the datapath through ctrl_type, reads status_type.
`default_nettype none
module ess_ctrl
   import ess_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [1:0] req_type,
   input  wire status_type stat,
   output ctrl_type        ctl,
   output logic            busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      ctl.sel = SEL_NONE;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE, ST_VEC_WAIT, ST_FRAME_WAIT: begin
            busy = 1'b0;
            if (start) begin
               case (req_type)
                  REQ_RAISE: ctl.raise = 1'b1;
                  REQ_TAKE: begin
                     if (state_ff == ST_IDLE) begin
                        ctl.latch_regs = 1'b1;
                        if (stat.found) begin
                           ctl.clr_count = 1'b1;
                           state_in = ST_PUSH;
                        end
                     end
                  end
                  REQ_RET: begin
                     if (state_ff == ST_IDLE) begin
                        ctl.emit = 1'b1;
                        if (stat.ret_valid) begin
                           ctl.do_return = 1'b1;
                           ctl.sel = SEL_MODE;
                           ctl.clr_count = 1'b1;
                           state_in = ST_RET_REGS;
                        end else begin
                           ctl.sel = SEL_ERR;
                           ctl.last = 1'b1;
                        end
                     end
                  end
                  REQ_DATA: begin
                     if (state_ff == ST_VEC_WAIT) begin
                        ctl.store_pc = 1'b1;
                        ctl.emit = 1'b1;
                        ctl.sel = SEL_PC;
                        ctl.clr_count = 1'b1;
                        if (stat.found) state_in = ST_PUSH;
                        else begin
                           ctl.last = 1'b1;
                           state_in = ST_IDLE;
                        end
                     end else if (state_ff == ST_FRAME_WAIT) begin
                        ctl.store_frame = 1'b1;
                        ctl.emit = 1'b1;
                        ctl.sel = SEL_FRAME_REG;
                        state_in = (stat.count == 3'd7) ? ST_POP_TAIL : ST_RET_REGS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PUSH: begin
            ctl.emit = 1'b1;
            ctl.sel = SEL_PUSH;
            ctl.inc_count = 1'b1;
            if (stat.count == 3'd7) state_in = ST_ENTRY_REGS;
         end
         ST_ENTRY_REGS: begin
            // lr, sp, mode, ipsr, vector read; count wraps back from 0
            ctl.emit = 1'b1;
            ctl.inc_count = 1'b1;
            case (stat.count)
               3'd0: ctl.sel = SEL_LR;
               3'd1: ctl.sel = SEL_SP;
               3'd2: ctl.sel = SEL_MODE;
               3'd3: ctl.sel = SEL_IPSR;
               default: begin
                  ctl.sel = SEL_VEC;
                  ctl.last = 1'b1;
                  ctl.enter = 1'b1;
                  ctl.clr_count = 1'b1;
                  ctl.inc_count = 1'b0;
                  state_in = ST_VEC_WAIT;
               end
            endcase
         end
         ST_RET_REGS: begin
            // after return: ipsr then first read; after a word: next read
            ctl.emit = 1'b1;
            if (stat.ret_phase) begin
               ctl.sel = SEL_IPSR;
            end else begin
               ctl.sel = SEL_FRAME_READ;
               ctl.last = 1'b1;
               state_in = ST_FRAME_WAIT;
            end
         end
         ST_POP_TAIL: begin
            ctl.emit = 1'b1;
            ctl.sel = SEL_SP;
            ctl.pop_sp = 1'b1;
            ctl.last = 1'b1;
            ctl.clr_count = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[rtl/core/ess_datapath.sv]
// Datapath of the exception stacking sequencer: architectural state,
// pending scan, frame words and result formation. Uses ess_pkg.
`default_nettype none
module ess_datapath
   import ess_pkg::*;
#(
   parameter int NUM_EXCEPTIONS = NumExceptionsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_item_type req,
   input  wire ctrl_type     ctl,
   output status_type        stat,
   output rsp_item_type      rsp,
   output logic              rsp_strobe
);
   localparam logic [31:0] ExcMask =
      (NUM_EXCEPTIONS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << NUM_EXCEPTIONS) - 32'd1);

   logic [31:0] pend_ff;
   logic        hmode_ff, msp_ff;
   logic [4:0]  scan_ff;
   logic [31:0] sp_ff, lr_ff, pc_ff, apsr_ff;
   logic [31:0] gpr_ff [5];
   logic [2:0]  count_ff;
   logic        ret_phase_ff;   // set by a return until its ipsr result
   logic        vec_wait_ff;    // entry done, vector word still due
   logic [4:0]  id_ff;          // exception being entered
   rsp_item_type rsp_ff, rsp_in;
   logic        strobe_ff;

   // Find lowest pending bit; while a vector is due, search above the scan index.
   logic [31:0] search;
   logic [4:0]  found_id;
   logic        found;
   always_comb begin
      search = pend_ff & ExcMask;
      if (vec_wait_ff)
         search = (scan_ff == 5'd31) ? 32'd0 : (search & ~((32'd2 << scan_ff) - 32'd1));
      found = |search;
      found_id = '0;
      for (int i = 31; i >= 0; i--)
         if (search[i]) found_id = 5'(i);
   end

   logic [3:0] nib;
   logic       ret_ok;
   assign nib = req.data_word[3:0];
   assign ret_ok = (nib == 4'h1) || (nib == 4'h9) || (nib == 4'hD);

   assign stat.found = found;
   assign stat.ret_valid = ret_ok;
   assign stat.ret_phase = ret_phase_ff;
   assign stat.count = count_ff;

   logic [31:0] frame_sp, push_word, exc_lr;
   assign frame_sp = sp_ff - 32'h20;
   assign exc_lr = hmode_ff ? 32'hFFFF_FFF1 : (msp_ff ? 32'hFFFF_FFF9 : 32'hFFFF_FFFD);
   always_comb begin
      case (count_ff)
         3'd0, 3'd1, 3'd2, 3'd3, 3'd4: push_word = gpr_ff[count_ff];
         3'd5: push_word = lr_ff;
         3'd6: push_word = pc_ff - 32'h4;
         default: push_word = apsr_ff & 32'hFFFF_FDFF;
      endcase
   end

   logic [3:0] frame_tgt;
   assign frame_tgt = (count_ff == 3'd7) ? TGT_APSR : {1'b0, count_ff};

   always_comb begin
      rsp_in = '0;
      rsp_in.last = ctl.last;
      case (ctl.sel)
         SEL_PUSH: begin
            rsp_in.kind = KIND_WRITE;
            rsp_in.address = frame_sp + {27'd0, count_ff, 2'b00};
            rsp_in.value = push_word;
         end
         SEL_LR: begin
            rsp_in.kind = KIND_REG; rsp_in.target = TGT_LR; rsp_in.value = exc_lr;
         end
         SEL_SP: begin
            rsp_in.kind = KIND_REG; rsp_in.target = TGT_SP;
            rsp_in.value = ctl.pop_sp ? sp_ff + 32'h20 : frame_sp;
         end
         SEL_MODE: begin
            rsp_in.kind = KIND_REG; rsp_in.target = TGT_MODE;
            if (ctl.do_return)
               rsp_in.value = {30'd0, nib != 4'hD, nib == 4'h1};
            else
               rsp_in.value = 32'd3;
         end
         SEL_IPSR: begin
            rsp_in.kind = KIND_REG; rsp_in.target = TGT_IPSR;
            rsp_in.value = ret_phase_ff ? 32'd0 : {27'd0, id_ff};
         end
         SEL_VEC: begin
            rsp_in.kind = KIND_READ; rsp_in.address = {25'd0, id_ff, 2'b00};
         end
         SEL_PC: begin
            rsp_in.kind = KIND_REG; rsp_in.target = TGT_PC; rsp_in.value = req.data_word;
         end
         SEL_FRAME_REG: begin
            rsp_in.kind = KIND_REG; rsp_in.target = frame_tgt;
            rsp_in.value = (count_ff == 3'd7) ? (req.data_word & 32'hF000_0000)
                                              : req.data_word;
         end
         SEL_FRAME_READ: begin
            rsp_in.kind = KIND_READ;
            rsp_in.address = sp_ff + {27'd0, count_ff, 2'b00};
         end
         SEL_APSR: begin
            rsp_in.kind = KIND_REG; rsp_in.target = TGT_APSR;
         end
         SEL_ERR: begin
            rsp_in.kind = KIND_ERR; rsp_in.value = req.data_word;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         hmode_ff <= 1'b0;
         msp_ff <= 1'b1;
         scan_ff <= '0;
         sp_ff <= '0; lr_ff <= '0; pc_ff <= '0; apsr_ff <= '0;
         count_ff <= '0;
         ret_phase_ff <= 1'b0;
         vec_wait_ff <= 1'b0;
         id_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.emit;
         if (ctl.raise) pend_ff <= pend_ff | (req.pending_mask & ExcMask);
         if (ctl.latch_regs) begin
            lr_ff <= req.reg_lr; pc_ff <= req.reg_pc;
            apsr_ff <= req.reg_apsr; sp_ff <= req.reg_sp;
         end
         // latch the exception id on take or after a vector
         if ((ctl.latch_regs || ctl.store_pc) && found) id_ff <= found_id;
         if (ctl.enter) begin
            lr_ff <= exc_lr;
            sp_ff <= frame_sp;
            hmode_ff <= 1'b1; msp_ff <= 1'b1;
            scan_ff <= id_ff;
            vec_wait_ff <= 1'b1;
            pend_ff <= (pend_ff & ~(32'd1 << id_ff))
                       | (ctl.raise ? (req.pending_mask & ExcMask) : 32'd0);
         end
         if (ctl.store_pc) begin
            pc_ff <= req.data_word;
            vec_wait_ff <= 1'b0;
         end
         if (ctl.do_return) begin
            hmode_ff <= nib == 4'h1;
            msp_ff <= nib != 4'hD;
            sp_ff <= req.reg_sp;
            ret_phase_ff <= 1'b1;
         end
         if (ctl.sel == SEL_IPSR) ret_phase_ff <= 1'b0;
         if (ctl.store_frame) begin
            case (count_ff)
               3'd5: lr_ff <= req.data_word;
               3'd6: pc_ff <= req.data_word;
               3'd7: apsr_ff <= req.data_word & 32'hF000_0000;
               default: ;
            endcase
            count_ff <= count_ff + 3'd1;
         end
         if (ctl.pop_sp) sp_ff <= sp_ff + 32'h20;
         if (ctl.clr_count) count_ff <= '0;
         else if (ctl.inc_count) count_ff <= count_ff + 3'd1;
      end
   end

   // saved registers: no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (ctl.latch_regs) begin
         gpr_ff[0] <= req.reg_r0; gpr_ff[1] <= req.reg_r1;
         gpr_ff[2] <= req.reg_r2; gpr_ff[3] <= req.reg_r3;
         gpr_ff[4] <= req.reg_r12;
      end
      if (ctl.store_frame && count_ff < 3'd5) gpr_ff[count_ff] <= req.data_word;
   end

   assign rsp = rsp_ff;
   assign rsp_strobe = strobe_ff;
endmodule
`default_nettype wire

[rtl/core/exception_stacking_sequencer.sv]
// Exception entry/return sequencer. Results leave one per cycle from a register,
// in the cycle after the step that forms them. An entry emits 13 results (8 frame
// writes, lr, sp, mode, ipsr, vector read) and holds busy while it runs after the
// take or vector item that starts it; a valid return emits 3 and holds busy;
// each frame word emits 2 and holds busy; other items do not hold busy.
// The receiver cannot stall. Synchronous active-high reset clears all control state.
`default_nettype none
module exception_stacking_sequencer
   import ess_pkg::*;
#(
   parameter int NUM_EXCEPTIONS = NumExceptionsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_item_type req_item,
   output rsp_item_type      rsp_item,
   output logic              rsp_strobe
);
   ctrl_type   ctl;
   status_type stat;

   ess_ctrl u_ctrl (
      .clock, .reset, .start,
      .req_type(req_item.req_type),
      .stat, .ctl, .busy
   );

   ess_datapath #(.NUM_EXCEPTIONS(NUM_EXCEPTIONS)) u_dp (
      .clock, .reset, .req(req_item), .ctl, .stat,
      .rsp(rsp_item), .rsp_strobe
   );
endmodule
`default_nettype wire

[rtl/core/ess_checker.sv]
// Port-level checker for the exception stacking sequencer, bound to the top.
// Uses ess_pkg and the assertion macro header.
`default_nettype none
`include "exception_stacking_sequencer_assert.svh"
module ess_port_checker
   import ess_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         busy,
   input wire rsp_item_type rsp_item,
   input wire logic         rsp_strobe
);
   `ESS_ASSERT_IMP(a_err_last, clock, reset, rsp_strobe && rsp_item.kind == KIND_ERR, rsp_item.last, "error result not last")
   `ESS_ASSERT_IMP(a_read_zero, clock, reset, rsp_strobe && rsp_item.kind == KIND_READ, rsp_item.value == 32'd0, "read request carries data")
   `ESS_ASSERT_NEXT(a_busy_emits, clock, reset, busy, rsp_strobe, "busy cycle without a result")
   `ESS_ASSERT_IMP(a_write_target, clock, reset, rsp_strobe && rsp_item.kind == KIND_WRITE, rsp_item.target == 4'd0, "write with a target")
endmodule

bind exception_stacking_sequencer ess_port_checker u_ess_checker (
   .clock, .reset, .busy, .rsp_item, .rsp_strobe
);
`default_nettype wire
